[rtl/echo_pulse_timer_spi_readout_macros.svh]
// Assertion helpers shared by the core and output-register RTL files.
`ifndef ECHO_PULSE_TIMER_SPI_READOUT_MACROS_SVH
`define ECHO_PULSE_TIMER_SPI_READOUT_MACROS_SVH

// Checked on every clock edge outside reset.
`define EPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define EPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/eptsr_pkg.sv]
package eptsr_pkg;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ECHO = 2'd1;
  localparam logic [1:0] CMD_HOST = 2'd2;

  localparam logic [7:0] HOST_LATCH   = 8'd0;
  localparam logic [7:0] HOST_HIGH    = 8'd1;
  localparam logic [7:0] HOST_LOW     = 8'd2;
  localparam logic [7:0] HOST_NIB_SUM = 8'd3;
  localparam logic [7:0] HOST_INV_SUM = 8'd4;

  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  typedef struct packed {
    logic [1:0] cmd;
    logic       echo_level;
    logic [7:0] host_byte;
  } item_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } result_t;

  function automatic logic [7:0] nibble_sum(input logic [7:0] b);
    nibble_sum = {4'd0, b[7:4]} + {4'd0, b[3:0] & NIBBLE_MASK};
  endfunction

  // new = (count*2 + old*6) >> 3, all terms in 19 bits
  function automatic logic [15:0] filter_step(input logic [15:0] count,
                                              input logic [15:0] old);
    logic [18:0] acc;
    acc = {2'd0, count, 1'b0} + {1'b0, old, 2'd0} + {2'd0, old, 1'b0};
    filter_step = acc[18:3];
  endfunction

endpackage

[rtl/eptsr_in_reg.sv]
module eptsr_in_reg
  import eptsr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item_in,
  input  logic  take,
  output logic  vld,
  output item_t item
);

  logic load;

  assign item_stall = vld && !take;
  assign load       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (take) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

[rtl/eptsr_core.sv]
module eptsr_core
  import eptsr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  `include "echo_pulse_timer_spi_readout_macros.svh"

  logic [15:0] pulse_counter;
  logic        sampling_flag;
  logic [15:0] smoothed_reading;
  logic [7:0]  latched_high;
  logic [7:0]  latched_low;
  logic [7:0]  nibble_checksum;
  logic [7:0]  inverted_checksum;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_counter     <= '0;
      sampling_flag     <= 1'b0;
      smoothed_reading  <= '0;
      latched_high      <= '0;
      latched_low       <= '0;
      nibble_checksum   <= '0;
      inverted_checksum <= '0;
    end else if (fire) begin
      case (item.cmd)
        CMD_TICK: begin
          pulse_counter <= pulse_counter + 16'd1;
        end
        CMD_ECHO: begin
          if (item.echo_level) begin
            pulse_counter <= '0;
            sampling_flag <= 1'b1;
          end else begin
            smoothed_reading <= filter_step(pulse_counter, smoothed_reading);
            sampling_flag    <= 1'b0;
          end
        end
        CMD_HOST: begin
          if (item.host_byte == HOST_LATCH) begin
            latched_high      <= smoothed_reading[15:8];
            latched_low       <= smoothed_reading[7:0];
            nibble_checksum   <= nibble_sum(smoothed_reading[15:8])
                               + nibble_sum(smoothed_reading[7:0]);
            inverted_checksum <= ~smoothed_reading[15:8] + ~smoothed_reading[7:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.vld  = 1'b0;
    res.data = '0;
    if (item.cmd == CMD_HOST) begin
      case (item.host_byte)
        HOST_HIGH: begin
          res.vld  = 1'b1;
          res.data = latched_high;
        end
        HOST_LOW: begin
          res.vld  = 1'b1;
          res.data = latched_low;
        end
        HOST_NIB_SUM: begin
          res.vld  = 1'b1;
          res.data = nibble_checksum;
        end
        HOST_INV_SUM: begin
          res.vld  = 1'b1;
          res.data = inverted_checksum;
        end
        default: begin
          res.vld = 1'b0;
        end
      endcase
    end
  end

  `EPT_ASSERT(a_rise_clears, fire && item.cmd == CMD_ECHO && item.echo_level |=> pulse_counter == 16'd0 && sampling_flag, "rising edge did not clear counter")
  `EPT_ASSERT(a_tick_inc, fire && item.cmd == CMD_TICK |=> pulse_counter == $past(pulse_counter) + 16'd1, "tick did not advance counter")
  `EPT_ASSERT(a_idle_hold, !fire |=> $stable(smoothed_reading) && $stable(latched_high), "state moved without a transaction")
  `EPT_ASSERT(a_reply_kind, res.vld |-> item.cmd == CMD_HOST && item.host_byte != HOST_LATCH, "reply for a non-read item")

endmodule

[rtl/eptsr_out_reg.sv]
module eptsr_out_reg
  import eptsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  result_t    res,
  output logic       open,
  output logic       reply_valid,
  input  logic       reply_stall,
  output logic [7:0] reply_byte
);

  `include "echo_pulse_timer_spi_readout_macros.svh"

  logic load;

  // the register can take a new result once the held one leaves or it is empty
  assign open = !reply_valid || !reply_stall;
  assign load = take && res.vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (load) begin
      reply_valid <= 1'b1;
    end else if (!reply_stall) begin
      reply_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      reply_byte <= res.data;
    end
  end

  `EPT_ASSERT(a_no_overwrite, reply_valid && reply_stall |-> !load, "held reply overwritten")
  `EPT_ASSERT_ALWAYS(a_reset_empty, rst |=> !reply_valid, "reply valid after reset")

endmodule

[rtl/echo_pulse_timer_spi_readout.sv]
// An accepted item is held in the input register, its reply in the reply
// register. Throughput: one item per cycle unless a reply waits; each register
// holds one transaction, and the input side stalls only while a reply waits.
// Reset: synchronous, active high; counter, flag, reading and latched bytes
// clear to zero and both registers empty.
module echo_pulse_timer_spi_readout
  import eptsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] cmd,
  input  logic       echo_level,
  input  logic [7:0] host_byte,
  output logic       reply_valid,
  input  logic       reply_stall,
  output logic [7:0] reply_byte
);

  item_t   item_in;
  item_t   item;
  logic    vld;
  logic    open;
  logic    take;
  result_t res;

  assign item_in.cmd        = cmd;
  assign item_in.echo_level = echo_level;
  assign item_in.host_byte  = host_byte;

  assign take = vld && open;

  eptsr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_in    (item_in),
    .take       (take),
    .vld        (vld),
    .item       (item)
  );

  eptsr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (take),
    .item (item),
    .res  (res)
  );

  eptsr_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .res         (res),
    .open        (open),
    .reply_valid (reply_valid),
    .reply_stall (reply_stall),
    .reply_byte  (reply_byte)
  );

endmodule
